// ----- hw/rtl/plam_pkg.sv -----
`default_nettype none
package plam_pkg;

  localparam int COORD_W    = 12;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
  localparam int CUM_W      = 25;
  localparam int SQ_W       = 25;   // dx^2 + dy^2
  localparam int TGT_W      = FRAC_W + CUM_W;
  localparam int R_W        = CUM_W + FRAC_SHIFT;
  localparam int SCALE_W    = 10;
  localparam int OFF_W      = 13;
  localparam int POS_W      = 16;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 2;

  typedef enum logic [REQ_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE = 2'd0,
    CFG_OFF_X = 2'd1,
    CFG_OFF_Y = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LAST_RD,
    BK_SQY,
    BK_SQRT,
    BK_APPLY,
    BK_SCAN,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_DIV,
    BK_MAP_MUL,
    BK_MAP_ADD,
    BK_RESULT
  } bk_state_e;

  typedef struct packed {
    op_e                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [FRAC_W-1:0]  frac;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/plam_if.sv -----
`default_nettype none
interface plam_req_if;
  logic                              valid;
  logic                              ready;
  logic [plam_pkg::REQ_W-1:0]        req_type;
  logic [plam_pkg::COORD_W-1:0]      point_x;
  logic [plam_pkg::COORD_W-1:0]      point_y;
  logic [plam_pkg::FRAC_W-1:0]       length_fraction;
  modport source (output valid, req_type, point_x, point_y, length_fraction, input ready);
  modport sink   (input valid, req_type, point_x, point_y, length_fraction, output ready);
endinterface

interface plam_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [plam_pkg::STAT_W-1:0]       status;
  logic signed [plam_pkg::POS_W-1:0] pos_x;
  logic signed [plam_pkg::POS_W-1:0] pos_y;
  modport source (output valid, status, pos_x, pos_y, input ready);
  modport sink   (input valid, status, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/polyline_arc_length_mapper_top.sv -----
// Clear, unused code, empty query, first point: from idle straight to the result state.
// Append: last point read, squares, bit-serial square root, then the table write.
// Query: last point read, scan over breakpoints (up to the point count),
//   one store read a cycle, then on a hit a 12-step divider per coordinate; scale and offset last.
// Throughput: one item at a time in the back end; a 2-beat queue keeps intake open.
// Reset (async, active low): table empty, scale 1.0, offsets 0; store contents undefined.
`default_nettype none
module polyline_arc_length_mapper_top #(
  parameter int MAX_POINTS     = 256,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  plam_req_if.sink                               req_i,
  plam_rsp_if.source                             rsp_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [plam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [plam_pkg::CFG_W-1:0]        cfg_wdata_i
);

  // config registers
  logic [plam_pkg::SCALE_W-1:0]      scale_q;
  logic signed [plam_pkg::OFF_W-1:0] off_x_q, off_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= plam_pkg::SCALE_W'(256);   // 1.0 in Q2.8
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        plam_pkg::CFG_SCALE: scale_q <= cfg_wdata_i[plam_pkg::SCALE_W-1:0];
        plam_pkg::CFG_OFF_X: off_x_q <= cfg_wdata_i;
        plam_pkg::CFG_OFF_Y: off_y_q <= cfg_wdata_i;
        default: ;   // unmapped index: write ignored
      endcase
    end
  end

  plam_pkg::item_t item;
  logic            item_valid, item_ready;
  plam_pkg::res_t  res;
  logic            res_valid;

  // front end: decode, clamp fraction, queue beats
  plam_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // back end: table store, sqrt, breakpoint scan, interpolation, mapping
  plam_back #(
    .MAX_POINTS     (MAX_POINTS),
    .DIST_FRAC_BITS (DIST_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .scale_i      (scale_q),
    .off_x_i      (off_x_q),
    .off_y_i      (off_y_q),
    .res_o        (res),
    .res_valid_o  (res_valid),
    .res_ready_i  (rsp_o.ready)
  );

  assign rsp_o.valid  = res_valid;
  assign rsp_o.status = res.status;
  assign rsp_o.pos_x  = res.pos_x;
  assign rsp_o.pos_y  = res.pos_y;

endmodule
`default_nettype wire

// ----- hw/rtl/plam_front.sv -----
`default_nettype none
module plam_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  plam_req_if.sink          req_i,
  output plam_pkg::item_t   item_o,
  output logic              item_valid_o,
  input  wire logic         item_ready_i
);

  plam_pkg::item_t q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] q_cnt_q;
  logic       push, pop;
  plam_pkg::item_t cls;

  // decode request and clamp fraction
  always_comb begin
    cls.x    = req_i.point_x;
    cls.y    = req_i.point_y;
    cls.frac = (req_i.length_fraction > plam_pkg::FRAC_ONE) ?
               plam_pkg::FRAC_ONE : req_i.length_fraction;
    cls.op   = plam_pkg::op_e'(req_i.req_type);
  end

  assign req_i.ready  = (q_cnt_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (q_cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      q_cnt_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
        2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
        default: q_cnt_q <= q_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_ptr_q] <= cls;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3) else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_cnt_q == 2'd2 && !pop) |=> q_cnt_q == 2'd2) else $error("full queue changed count");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_cnt_q != 2'd0) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hw/rtl/plam_back.sv -----
`default_nettype none
module plam_back #(
  parameter int MAX_POINTS     = 256,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire plam_pkg::item_t                      item_i,
  input  wire logic                                 item_valid_i,
  output logic                                      item_ready_o,
  input  wire logic [plam_pkg::SCALE_W-1:0]         scale_i,
  input  wire logic signed [plam_pkg::OFF_W-1:0]    off_x_i,
  input  wire logic signed [plam_pkg::OFF_W-1:0]    off_y_i,
  output plam_pkg::res_t                            res_o,
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int CW     = AW + 1;
  localparam int SQW    = plam_pkg::SQ_W + 1 + 2 * DIST_FRAC_BITS;
  localparam int HW     = SQW / 2;
  localparam int STEP_W = $clog2(HW);
  localparam int CRD    = plam_pkg::COORD_W;
  localparam int CUMW   = plam_pkg::CUM_W;
  localparam int RW     = plam_pkg::R_W;
  localparam int RLO    = RW / 2;
  localparam int RHI    = RW - RLO;
  localparam int FS     = plam_pkg::FRAC_SHIFT;
  localparam int PRW    = CRD + plam_pkg::SCALE_W;
  localparam int VW     = plam_pkg::POS_W + 1;
  localparam logic [CUMW-1:0] CUM_MAX = '1;

  plam_pkg::bk_state_e state_q, state_d;

  // point store
  logic [CRD-1:0]  mx_q [MAX_POINTS];
  logic [CRD-1:0]  my_q [MAX_POINTS];
  logic [CUMW-1:0] mc_q [MAX_POINTS];
  logic [CRD-1:0]  rd_x_q, rd_y_q;
  logic [CUMW-1:0] rd_c_q;
  logic            we;
  logic [AW-1:0]   wa, ra;
  logic [CRD-1:0]  wx, wy;
  logic [CUMW-1:0] wc;

  plam_pkg::item_t item_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   cnt_m1;
  logic [CRD-1:0]  last_y_q;
  logic [CUMW-1:0] last_c_q;
  logic [2*CRD-1:0] acc_q;
  logic [SQW-1:0]  sq_opnd_q;
  logic [HW+1:0]   sq_rem_q;
  logic [HW-1:0]   sq_root_q;
  logic [STEP_W-1:0] step_q;
  logic [plam_pkg::TGT_W-1:0] target_q;
  logic [AW-1:0]   j_q;
  logic [CRD-1:0]  prev_x_q, prev_y_q;
  logic [CUMW-1:0] prev_c_q;
  logic [CRD-1:0]  xi_q, yi_q, xj_q, yj_q;
  logic [RW-1:0]   r_q;
  logic [CUMW-1:0] dc_q;
  logic            ph_q;
  logic [CRD+RLO-1:0] n_lo_q;
  logic [RW-1:0]   rem_q;
  logic [CRD-1:0]  low_q, quo_q;
  logic [CRD-1:0]  rx_q, ry_q;
  logic [PRW-1:0]  prod_q;
  plam_pkg::res_t  res_q, out_q;
  logic            out_valid_q, out_load;

  // combinational helpers
  logic [CRD-1:0]  dx_mag, dy_mag;
  logic [2*CRD-1:0] dy_sq;
  logic [2*CRD:0]  acc_sum;
  logic [HW+3:0]   sq_rem2, sq_trial;
  logic            sq_ge;
  logic [CUMW:0]   cum_sum;
  logic            hit, scan_end;
  logic signed [CRD:0] dd;
  logic [CRD-1:0]  dd_mag;
  logic [CRD+RHI-1:0] prod_hi;
  logic [CRD+RW-1:0]  n_full;
  logic [RW-1:0]   den;
  logic [RW:0]     rem2, rem2_sub;
  logic            div_ge;
  logic [CRD-1:0]  q_fin;
  logic            rem_nz;
  logic [CRD:0]    q_adj;
  logic [CRD+1:0]  crd_new;
  logic [CRD-1:0]  map_in;
  logic signed [VW-1:0] map_v;
  logic signed [plam_pkg::POS_W-1:0] map_sat;
  logic signed [plam_pkg::OFF_W-1:0] map_off;

  assign cnt_m1 = cnt_q - CW'(1);

  always_comb begin
    dx_mag   = (item_q.x >= rd_x_q) ? item_q.x - rd_x_q : rd_x_q - item_q.x;
    dy_mag   = (item_q.y >= last_y_q) ? item_q.y - last_y_q : last_y_q - item_q.y;
    dy_sq    = dy_mag * dy_mag;
    acc_sum  = {1'b0, acc_q} + {1'b0, dy_sq};
    sq_rem2  = {sq_rem_q, sq_opnd_q[SQW-1 -: 2]};
    sq_trial = {2'b00, sq_root_q, 2'b01};
    sq_ge    = sq_rem2 >= sq_trial;
    cum_sum  = {1'b0, last_c_q} + (CUMW+1)'(sq_root_q);
    hit      = {rd_c_q, {FS{1'b0}}} > target_q;
    scan_end = (j_q == cnt_m1[AW-1:0]);
    dd       = ph_q ? ($signed({1'b0, yj_q}) - $signed({1'b0, yi_q}))
                    : ($signed({1'b0, xj_q}) - $signed({1'b0, xi_q}));
    dd_mag   = dd[CRD] ? CRD'(-dd) : dd[CRD-1:0];
    prod_hi  = dd_mag * r_q[RW-1:RLO];
    n_full   = {prod_hi, {RLO{1'b0}}} + (CRD+RW)'(n_lo_q);
    den      = {dc_q, {FS{1'b0}}};
    rem2     = {rem_q, low_q[CRD-1]};
    rem2_sub = rem2 - {1'b0, den};
    div_ge   = rem2 >= {1'b0, den};
    q_fin    = {quo_q[CRD-2:0], div_ge};
    rem_nz   = div_ge ? (rem2_sub != '0) : (rem2 != '0);
    q_adj    = {1'b0, q_fin} + (CRD+1)'(dd[CRD] && rem_nz);
    crd_new  = dd[CRD] ? ({2'b00, (ph_q ? yi_q : xi_q)} - {1'b0, q_adj})
                       : ({2'b00, (ph_q ? yi_q : xi_q)} + {2'b00, q_fin});
    map_in   = ph_q ? ry_q : rx_q;
    map_off  = ph_q ? off_y_i : off_x_i;
    map_v    = $signed({{(VW-PRW+8){1'b0}}, prod_q[PRW-1:8]})
             + $signed({{(VW-plam_pkg::OFF_W){map_off[plam_pkg::OFF_W-1]}}, map_off});
    if (map_v[VW-1] != map_v[VW-2]) begin
      map_sat = map_v[VW-1] ? {1'b1, {(plam_pkg::POS_W-1){1'b0}}}
                            : {1'b0, {(plam_pkg::POS_W-1){1'b1}}};
    end else begin
      map_sat = map_v[plam_pkg::POS_W-1:0];
    end
  end

  assign out_load    = (state_q == plam_pkg::BK_RESULT) && (!out_valid_q || res_ready_i);
  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

  // next state, store port control
  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    we           = 1'b0;
    wa           = '0;
    wx           = item_q.x;
    wy           = item_q.y;
    wc           = '0;
    ra           = '0;
    case (state_q)
      plam_pkg::BK_IDLE: begin
        item_ready_o = 1'b1;
        ra           = cnt_m1[AW-1:0];
        wx           = item_i.x;
        wy           = item_i.y;
        if (item_valid_i) begin
          case (item_i.op)
            plam_pkg::OP_APPEND: begin
              if (cnt_q == '0) begin
                we      = 1'b1;
                state_d = plam_pkg::BK_RESULT;
              end else begin
                state_d = plam_pkg::BK_LAST_RD;
              end
            end
            plam_pkg::OP_QUERY: begin
              state_d = (cnt_q == '0) ? plam_pkg::BK_RESULT : plam_pkg::BK_LAST_RD;
            end
            default: state_d = plam_pkg::BK_RESULT;
          endcase
        end
      end
      plam_pkg::BK_LAST_RD: begin
        ra      = '0;
        state_d = (item_q.op == plam_pkg::OP_APPEND) ? plam_pkg::BK_SQY : plam_pkg::BK_SCAN;
      end
      plam_pkg::BK_SQY: state_d = plam_pkg::BK_SQRT;
      plam_pkg::BK_SQRT: begin
        if (step_q == STEP_W'(HW - 1)) state_d = plam_pkg::BK_APPLY;
      end
      plam_pkg::BK_APPLY: begin
        state_d = plam_pkg::BK_RESULT;
        if (sq_root_q == '0) begin
          we = 1'b1;
          wa = cnt_m1[AW-1:0];
          wc = last_c_q;
        end else if (cnt_q != CW'(MAX_POINTS)) begin
          we = 1'b1;
          wa = cnt_q[AW-1:0];
          wc = cum_sum[CUMW] ? CUM_MAX : cum_sum[CUMW-1:0];
        end
      end
      plam_pkg::BK_SCAN: begin
        ra = j_q + AW'(1);
        if (hit)           state_d = plam_pkg::BK_MUL_LO;
        else if (scan_end) state_d = plam_pkg::BK_MAP_MUL;
      end
      plam_pkg::BK_MUL_LO: state_d = plam_pkg::BK_MUL_HI;
      plam_pkg::BK_MUL_HI: state_d = plam_pkg::BK_DIV;
      plam_pkg::BK_DIV: begin
        if (step_q == STEP_W'(CRD - 1)) begin
          state_d = ph_q ? plam_pkg::BK_MAP_MUL : plam_pkg::BK_MUL_LO;
        end
      end
      plam_pkg::BK_MAP_MUL: state_d = plam_pkg::BK_MAP_ADD;
      plam_pkg::BK_MAP_ADD: state_d = ph_q ? plam_pkg::BK_RESULT : plam_pkg::BK_MAP_MUL;
      plam_pkg::BK_RESULT: begin
        if (out_load) state_d = plam_pkg::BK_IDLE;
      end
      default: state_d = plam_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= plam_pkg::BK_IDLE;
    else         state_q <= state_d;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mx_q[wa] <= wx;
      my_q[wa] <= wy;
      mc_q[wa] <= wc;
    end
    rd_x_q <= mx_q[ra];
    rd_y_q <= my_q[ra];
    rd_c_q <= mc_q[ra];
  end

  // control counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == plam_pkg::BK_IDLE && item_valid_i) begin
        if (item_i.op == plam_pkg::OP_CLEAR) cnt_q <= '0;
        else if (item_i.op == plam_pkg::OP_APPEND && cnt_q == '0) cnt_q <= CW'(1);
      end
      if (state_q == plam_pkg::BK_APPLY && sq_root_q != '0 && cnt_q != CW'(MAX_POINTS)) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (out_load)         out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
    case (state_q)
      plam_pkg::BK_IDLE: begin
        item_q <= item_i;
        res_q  <= '{status: (item_i.op == plam_pkg::OP_QUERY && cnt_q == '0) ?
                            plam_pkg::STAT_EMPTY : plam_pkg::STAT_OK,
                    pos_x: '0, pos_y: '0};
      end
      plam_pkg::BK_LAST_RD: begin
        last_y_q <= rd_y_q;
        last_c_q <= rd_c_q;
        acc_q    <= dx_mag * dx_mag;
        target_q <= item_q.frac * rd_c_q;
        j_q      <= '0;
        rx_q     <= rd_x_q;
        ry_q     <= rd_y_q;
        ph_q     <= 1'b0;
      end
      plam_pkg::BK_SQY: begin
        sq_opnd_q <= {1'b0, acc_sum, {(2*DIST_FRAC_BITS){1'b0}}};
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        step_q    <= '0;
      end
      plam_pkg::BK_SQRT: begin
        sq_opnd_q <= {sq_opnd_q[SQW-3:0], 2'b00};
        sq_rem_q  <= sq_ge ? (HW+2)'(sq_rem2 - sq_trial) : (HW+2)'(sq_rem2);
        sq_root_q <= {sq_root_q[HW-2:0], sq_ge};
        step_q    <= step_q + STEP_W'(1);
      end
      plam_pkg::BK_APPLY: begin
        if (sq_root_q != '0 && cnt_q == CW'(MAX_POINTS)) res_q.status <= plam_pkg::STAT_FULL;
      end
      plam_pkg::BK_SCAN: begin
        if (hit) begin
          xi_q <= prev_x_q;
          yi_q <= prev_y_q;
          xj_q <= rd_x_q;
          yj_q <= rd_y_q;
          r_q  <= RW'(target_q - {prev_c_q, {FS{1'b0}}});
          dc_q <= rd_c_q - prev_c_q;
        end else begin
          prev_x_q <= rd_x_q;
          prev_y_q <= rd_y_q;
          prev_c_q <= rd_c_q;
          j_q      <= j_q + AW'(1);
        end
      end
      plam_pkg::BK_MUL_LO: n_lo_q <= dd_mag * r_q[RLO-1:0];
      plam_pkg::BK_MUL_HI: begin
        rem_q  <= n_full[CRD+RW-1:CRD];
        low_q  <= n_full[CRD-1:0];
        quo_q  <= '0;
        step_q <= '0;
      end
      plam_pkg::BK_DIV: begin
        rem_q  <= div_ge ? rem2_sub[RW-1:0] : rem2[RW-1:0];
        low_q  <= {low_q[CRD-2:0], 1'b0};
        quo_q  <= q_fin;
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(CRD - 1)) begin
          if (ph_q) ry_q <= crd_new[CRD-1:0];
          else      rx_q <= crd_new[CRD-1:0];
          ph_q <= ~ph_q;
        end
      end
      plam_pkg::BK_MAP_MUL: prod_q <= map_in * scale_i;
      plam_pkg::BK_MAP_ADD: begin
        if (ph_q) res_q.pos_y <= map_sat;
        else      res_q.pos_x <= map_sat;
        ph_q <= ~ph_q;
      end
      default: ;
    endcase
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS)) else $error("point count above table size");
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == plam_pkg::BK_DIV |-> rem_q < den) else $error("division remainder not below divisor");
  a_apply_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == plam_pkg::BK_APPLY |=> cnt_q >= $past(cnt_q)) else $error("append shrank table");

endmodule
`default_nettype wire

// ----- sim/plam_scoreboard.sv -----
`timescale 1ns / 1ps
`default_nettype none
module plam_scoreboard #(
  parameter int MAX_POINTS     = 256,
  parameter int DIST_FRAC_BITS = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  plam_req_if                                 req,
  plam_rsp_if                                 rsp,
  input  wire logic                           cfg_we_i,
  input  wire logic [plam_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [plam_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                                  mismatches_o,
  output int                                  outstanding_o
);

  localparam longint DIST_MAX = 64'd33554431;
  localparam longint ONE_Q16  = 64'd65536;

  logic [plam_pkg::COORD_W-1:0]      pt_x [MAX_POINTS];
  logic [plam_pkg::COORD_W-1:0]      pt_y [MAX_POINTS];
  logic [plam_pkg::CUM_W-1:0]        pt_cum [MAX_POINTS];
  int                                n_points;
  logic [plam_pkg::SCALE_W-1:0]      scale_q;
  logic signed [plam_pkg::OFF_W-1:0] off_x_q;
  logic signed [plam_pkg::OFF_W-1:0] off_y_q;
  plam_pkg::res_t                    pending_pos [$];

  function automatic longint seg_isqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  function automatic logic [plam_pkg::POS_W-1:0] scale_offset(longint c,
      logic signed [plam_pkg::OFF_W-1:0] off);
    longint v;
    v = (c * longint'(scale_q)) >>> 8;
    v = v + longint'(off);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[plam_pkg::POS_W-1:0];
  endfunction

  // Updates the point table and returns the mapped position for one beat.
  function automatic plam_pkg::res_t map_request(logic [plam_pkg::REQ_W-1:0] op,
      logic [plam_pkg::COORD_W-1:0] px, logic [plam_pkg::COORD_W-1:0] py,
      logic [plam_pkg::FRAC_W-1:0] fr);
    plam_pkg::res_t r;
    int     last, j, i;
    longint dx, dy, d, c, total, target, rem, den, rx, ry, f;
    r.status = plam_pkg::STAT_OK;
    r.pos_x  = '0;
    r.pos_y  = '0;
    case (op)
      plam_pkg::OP_CLEAR: n_points = 0;
      plam_pkg::OP_APPEND: begin
        if (n_points == 0) begin
          pt_x[0] = px; pt_y[0] = py; pt_cum[0] = '0;
          n_points = 1;
        end else begin
          last = n_points - 1;
          dx = longint'(px) - longint'(pt_x[last]);
          dy = longint'(py) - longint'(pt_y[last]);
          d = seg_isqrt((dx * dx + dy * dy) << (2 * DIST_FRAC_BITS));
          if (d == 0) begin
            pt_x[last] = px; pt_y[last] = py;
          end else if (n_points >= MAX_POINTS) begin
            r.status = plam_pkg::STAT_FULL;
          end else begin
            c = longint'(pt_cum[last]) + d;
            if (c > DIST_MAX) c = DIST_MAX;
            pt_x[n_points] = px; pt_y[n_points] = py;
            pt_cum[n_points] = c[plam_pkg::CUM_W-1:0];
            n_points++;
          end
        end
      end
      plam_pkg::OP_QUERY: begin
        if (n_points == 0) begin
          r.status = plam_pkg::STAT_EMPTY;
        end else begin
          last = n_points - 1;
          total = longint'(pt_cum[last]);
          rx = longint'(pt_x[last]);
          ry = longint'(pt_y[last]);
          f = longint'(fr);
          if (f > ONE_Q16) f = ONE_Q16;
          target = f * total;
          for (j = 0; j < n_points; j++)
            if (longint'(pt_cum[j]) * ONE_Q16 > target) break;
          if (n_points > 1 && total != 0 && j < n_points && j > 0) begin
            i = j - 1;
            rem = target - longint'(pt_cum[i]) * ONE_Q16;
            den = (longint'(pt_cum[j]) - longint'(pt_cum[i])) * ONE_Q16;
            rx = longint'(pt_x[i]) + floor_quot((longint'(pt_x[j]) - longint'(pt_x[i])) * rem, den);
            ry = longint'(pt_y[i]) + floor_quot((longint'(pt_y[j]) - longint'(pt_y[i])) * rem, den);
          end
          r.pos_x = scale_offset(rx, off_x_q);
          r.pos_y = scale_offset(ry, off_y_q);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plam_pkg::res_t want;
    if (!rst_ni) begin
      n_points = 0;
      scale_q = 10'd256;
      off_x_q = '0;
      off_y_q = '0;
      pending_pos.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (plam_pkg::cfg_idx_e'(cfg_idx_i))
          plam_pkg::CFG_SCALE: scale_q = cfg_wdata_i[plam_pkg::SCALE_W-1:0];
          plam_pkg::CFG_OFF_X: off_x_q = cfg_wdata_i[plam_pkg::OFF_W-1:0];
          plam_pkg::CFG_OFF_Y: off_y_q = cfg_wdata_i[plam_pkg::OFF_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        pending_pos.push_back(map_request(req.req_type, req.point_x, req.point_y,
                                          req.length_fraction));
      if (rsp.valid && rsp.ready) begin
        if (pending_pos.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = pending_pos.pop_front();
          if (rsp.status !== want.status) report("status", rsp.status, want.status);
          if (rsp.pos_x !== want.pos_x) report("pos_x", rsp.pos_x, want.pos_x);
          if (rsp.pos_y !== want.pos_y) report("pos_y", rsp.pos_y, want.pos_y);
        end
      end
    end
    outstanding_o = pending_pos.size();
  end

endmodule
`default_nettype wire

// ----- sim/tb_polyline_arc_length_mapper_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_polyline_arc_length_mapper_top;

  localparam int  TABLE_DEPTH = 256;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we;
  logic [plam_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [plam_pkg::CFG_W-1:0]     cfg_wdata;
  int                             mismatches;
  int                             outstanding;
  longint                         cycles = 0;

  plam_req_if req_bus ();
  plam_rsp_if rsp_bus ();

  polyline_arc_length_mapper_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  plam_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_bus),
    .rsp          (rsp_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog: well above the slowest legal run (full-table scans, long stalls).
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side stall pattern: the mode is picked at random from always ready,
  // coin-flip ready and long stall runs.
  int stall_mode = 0;
  int stall_run  = 0;
  always @(posedge clk_i) begin
    if (cycles % 128 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: rsp_bus.ready <= 1'b1;
      1: rsp_bus.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_run > 0) begin
          stall_run <= stall_run - 1;
          rsp_bus.ready <= 1'b0;
        end else begin
          stall_run <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
          rsp_bus.ready <= 1'b1;
        end
      end
    endcase
  end

  int burst_left = 0;
  logic [plam_pkg::COORD_W-1:0] last_x = '0;
  logic [plam_pkg::COORD_W-1:0] last_y = '0;

  // One request beat. Beats go out in bursts; a gap of random length (sometimes
  // none) comes before each new burst.
  task automatic send_beat(logic [plam_pkg::REQ_W-1:0] op, logic [plam_pkg::COORD_W-1:0] x,
                           logic [plam_pkg::COORD_W-1:0] y, logic [plam_pkg::FRAC_W-1:0] fr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    req_bus.valid           <= 1'b1;
    req_bus.req_type        <= op;
    req_bus.point_x         <= x;
    req_bus.point_y         <= y;
    req_bus.length_fraction <= fr;
    // ready is settled by the falling edge; the beat moves on the next rising one
    @(negedge clk_i);
    while (!req_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    burst_left--;
    if (op == plam_pkg::OP_APPEND) begin
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic append_pt(logic [plam_pkg::COORD_W-1:0] x, logic [plam_pkg::COORD_W-1:0] y);
    send_beat(plam_pkg::OP_APPEND, x, y, plam_pkg::FRAC_W'($urandom));
  endtask

  task automatic query_at(logic [plam_pkg::FRAC_W-1:0] fr);
    send_beat(plam_pkg::OP_QUERY, plam_pkg::COORD_W'($urandom),
              plam_pkg::COORD_W'($urandom), fr);
  endtask

  // Drop valid and wait until every result is back; config is only written after a drain.
  task automatic drain;
    req_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(plam_pkg::cfg_idx_e idx, logic [plam_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [plam_pkg::FRAC_W-1:0] pick_fraction;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return plam_pkg::FRAC_ONE;
      2: return plam_pkg::FRAC_W'($urandom_range(65537, 131071));  // clamps to one
      3: return plam_pkg::FRAC_W'($urandom_range(0, 15));
      default: return plam_pkg::FRAC_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Point near the last one, a repeat of it, or anywhere on the grid.
  task automatic append_random;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) append_pt(last_x, last_y);
    else if (k < 4)
      append_pt(last_x + plam_pkg::COORD_W'($urandom_range(0, 40) - 20),
                last_y + plam_pkg::COORD_W'($urandom_range(0, 40) - 20));
    else append_pt(plam_pkg::COORD_W'($urandom), plam_pkg::COORD_W'($urandom));
  endtask

  int sent = 0;
  int n_app, n_qry;

  initial begin
    req_bus.valid           = 1'b0;
    req_bus.req_type        = plam_pkg::OP_NOP;
    req_bus.point_x         = '0;
    req_bus.point_y         = '0;
    req_bus.length_fraction = '0;
    rsp_bus.ready           = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = plam_pkg::CFG_SCALE;
    cfg_wdata               = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, unused code, single point, repeated point,
    // extreme coordinates, fraction at zero, one, above one, tiny.
    query_at(17'h08000);
    send_beat(plam_pkg::OP_NOP, '1, '1, '1);
    send_beat(plam_pkg::OP_CLEAR, '1, '1, '1);
    append_pt('0, '0);
    query_at(17'h08000);
    append_pt('0, '0);
    append_pt(12'hFFF, 12'hFFF);
    append_pt(12'hFFF, '0);
    append_pt(12'hFFF, '0);
    query_at('0);
    query_at(17'd1);
    query_at(17'h08000);
    query_at(17'h0FFFF);
    query_at(plam_pkg::FRAC_ONE);
    query_at(17'h1FFFF);
    append_pt(12'hAAA, 12'h555);
    query_at(17'h0C000);
    send_beat(plam_pkg::OP_CLEAR, '0, '0, '0);
    query_at('0);
    drain();

    // Extreme register settings over a short path.
    write_reg(plam_pkg::CFG_SCALE, 13'd1023);
    write_reg(plam_pkg::CFG_OFF_X, 13'h0FFF);   // +4095
    write_reg(plam_pkg::CFG_OFF_Y, 13'h1000);   // -4096
    append_pt(12'd100, 12'd4000);
    append_pt(12'hFFF, 12'h000);
    query_at(17'h04000);
    query_at(plam_pkg::FRAC_ONE);
    drain();
    write_reg(plam_pkg::CFG_SCALE, '0);
    write_reg(plam_pkg::CFG_OFF_X, 13'h1000);
    write_reg(plam_pkg::CFG_OFF_Y, 13'h0FFF);
    query_at(17'h0A000);
    drain();
    sent = 24;

    // Random phases: new registers, then mostly a well-formed path build
    // followed by queries, with some noise beats mixed in.
    while (sent < 2000) begin
      write_reg(plam_pkg::CFG_SCALE, plam_pkg::CFG_W'($urandom_range(0, 1023)));
      write_reg(plam_pkg::CFG_OFF_X, plam_pkg::CFG_W'($urandom));
      write_reg(plam_pkg::CFG_OFF_Y, plam_pkg::CFG_W'($urandom));
      if ($urandom_range(0, 1) == 0) begin
        send_beat(plam_pkg::OP_CLEAR, plam_pkg::COORD_W'($urandom),
                  plam_pkg::COORD_W'($urandom), plam_pkg::FRAC_W'($urandom));
        sent++;
      end
      n_app = $urandom_range(1, 12);
      n_qry = $urandom_range(2, 20);
      for (int i = 0; i < n_app; i++) begin
        append_random();
        sent++;
      end
      for (int i = 0; i < n_qry; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(plam_pkg::REQ_W'($urandom_range(0, 3)), plam_pkg::COORD_W'($urandom),
                    plam_pkg::COORD_W'($urandom), plam_pkg::FRAC_W'($urandom));
        else
          query_at(pick_fraction());
        sent++;
      end
      // Once in a while fill the table past its end, repeats included.
      if ($urandom_range(0, 11) == 0) begin
        for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
          if (i % 64 == 63) append_pt(last_x, last_y);
          else append_pt(plam_pkg::COORD_W'($urandom), plam_pkg::COORD_W'($urandom));
          sent++;
        end
        for (int i = 0; i < 8; i++) begin
          query_at(pick_fraction());
          sent++;
        end
      end
      drain();
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- polyline_arc_length_mapper_top.f -----
hw/rtl/plam_pkg.sv
hw/rtl/plam_if.sv
hw/rtl/plam_front.sv
hw/rtl/plam_back.sv
hw/rtl/polyline_arc_length_mapper_top.sv
sim/plam_scoreboard.sv
sim/tb_polyline_arc_length_mapper_top.sv
